FILE: rtl/wildcard_pattern_matcher_top_assert.svh
// assertion macros used by the wildcard matcher top level
`ifndef WILDCARD_PATTERN_MATCHER_TOP_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wpm_pkg.sv
// shared types and constants of the wildcard matcher
package wpm_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_FINISH  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_TOO_LONG   = 2'd1,
    ERR_AFTER_TEXT = 2'd2,
    ERR_UNUSED     = 2'd3
  } err_e;

  // request travelling down the cell chain
  typedef struct packed {
    logic       vld;
    op_e        op;
    logic [7:0] sym;
    logic       m;     // new match bit of the left neighbor
    logic       diag;  // match bit of the left neighbor before this request
    logic       done;  // pattern byte already placed
    logic       hit;   // match bit of the last filled cell seen so far
    err_e       err;
  } token_t;

endpackage

FILE: rtl/wpm_head.sv
// front end: error checks, pattern length, empty-prefix match bit
module wpm_head import wpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_symbol,
  output token_t     tok_o
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             m0_r, m0_nxt;
  logic             text_r, text_nxt;
  err_e             err_r, err_nxt;
  token_t           tok_r, tok_nxt;
  op_e              op;

  assign op = op_e'(in_operation);

  always_comb begin
    len_nxt  = len_r;
    m0_nxt   = m0_r;
    text_nxt = text_r;
    err_nxt  = err_r;
    tok_nxt  = '{vld: 1'b0, op: op, sym: in_symbol, m: 1'b0, diag: 1'b0,
                 done: 1'b0, hit: 1'b0, err: ERR_NONE};
    if (in_valid) begin
      unique case (op)
        OP_PATTERN: begin
          if (text_r) begin
            if (err_r == ERR_NONE) err_nxt = ERR_AFTER_TEXT;
          end else if (len_r >= LEN_W'(PATTERN_DEPTH)) begin
            if (err_r == ERR_NONE) err_nxt = ERR_TOO_LONG;
          end else begin
            tok_nxt.vld = 1'b1;
            tok_nxt.m   = m0_r;
            len_nxt     = len_r + 1'b1;
          end
        end
        OP_TEXT: begin
          tok_nxt.vld  = 1'b1;
          tok_nxt.diag = m0_r;
          text_nxt     = 1'b1;
          m0_nxt       = 1'b0;
        end
        OP_FINISH: begin
          tok_nxt.vld = 1'b1;
          tok_nxt.hit = m0_r;
          tok_nxt.err = err_r;
          len_nxt     = '0;
          m0_nxt      = 1'b1;
          text_nxt    = 1'b0;
          err_nxt     = ERR_NONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      m0_r      <= 1'b1;
      text_r    <= 1'b0;
      err_r     <= ERR_NONE;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      len_r  <= len_nxt;
      m0_r   <= m0_nxt;
      text_r <= text_nxt;
      err_r  <= err_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/wpm_cell.sv
// one pattern position: stored byte, match bit, request register
module wpm_cell import wpm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  token_t tok_i,
  output token_t tok_o
);

  logic [7:0] pat_r, pat_nxt;
  logic       vld_r, vld_nxt;
  logic       m_r, m_nxt;
  token_t     tok_r, tok_nxt;
  logic       is_star;
  logic       single_hit;

  assign is_star    = (pat_r == STAR_BYTE);
  assign single_hit = (pat_r == ANY_BYTE) || (pat_r == tok_i.sym);

  always_comb begin
    pat_nxt = pat_r;
    vld_nxt = vld_r;
    m_nxt   = m_r;
    tok_nxt = tok_i;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OP_PATTERN: begin
          if (!tok_i.done && !vld_r) begin
            pat_nxt      = tok_i.sym;
            vld_nxt      = 1'b1;
            m_nxt        = tok_i.m && (tok_i.sym == STAR_BYTE);
            tok_nxt.done = 1'b1;
          end else begin
            tok_nxt.m = m_r;
          end
        end
        OP_TEXT: begin
          if (vld_r) begin
            // star takes the new left bit or keeps its own; others take the diagonal
            m_nxt        = is_star ? (tok_i.m | m_r) : (single_hit & tok_i.diag);
            tok_nxt.m    = m_nxt;
            tok_nxt.diag = m_r;
          end
        end
        OP_FINISH: begin
          if (vld_r) tok_nxt.hit = m_r;
          vld_nxt = 1'b0;
          m_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      m_r       <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
      m_r   <= m_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pat_r <= pat_nxt;
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/wildcard_pattern_matcher_top.sv
// wildcard matcher top level: front end, chain of pattern cells, result register
// path: a finish request is registered in the front end, then in each cell in turn,
// and last in the result register, which then carries its answer
// throughput: one request per cycle; pattern, text and finish requests flow as a wavefront
// set by the cell chain, one cell per cycle; only a stalled full result register holds it
// reset: synchronous active-low rst_n empties the pattern, sets the empty match bit and
// clears errors; pattern bytes themselves are not cleared, cells track their own fill
module wildcard_pattern_matcher_top import wpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic [1:0] out_error_code
);

`include "wildcard_pattern_matcher_top_assert.svh"

  // whole chain moves together; it halts only while a result waits under stall
  logic adv;
  // tok[0] leaves the front end, tok[i+1] leaves cell i
  token_t tok [PATTERN_DEPTH+1];
  token_t tail;
  logic   tail_finish;

  logic       out_valid_r, out_valid_nxt;
  logic       matched_r, matched_nxt;
  logic [1:0] err_code_r, err_code_nxt;

  // views of the result register for the checks below
  logic       err_result;
  logic       out_hold;
  logic [3:0] out_word;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // front end drops bad pattern bytes and injects requests into the chain
  wpm_head u_head (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_symbol    (in_symbol),
    .tok_o        (tok[0])
  );

  // one cell per pattern position; each request passes the cells in order
  for (genvar i = 0; i < PATTERN_DEPTH; i++) begin : g_cell
    wpm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  assign tail        = tok[PATTERN_DEPTH];
  assign tail_finish = tail.vld && (tail.op == OP_FINISH);

  // result register: a finish request leaving the last cell carries the answer
  always_comb begin
    out_valid_nxt = tail_finish;
    matched_nxt   = tail.hit && (tail.err == ERR_NONE);
    err_code_nxt  = tail.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      matched_r  <= matched_nxt;
      err_code_r <= err_code_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_matched    = matched_r;
  assign out_error_code = err_code_r;

  assign err_result = out_valid_r && (err_code_r != ERR_NONE);
  assign out_hold   = out_valid_r && out_stall;
  assign out_word   = {out_valid_r, matched_r, err_code_r};

  // a waiting result keeps its value until taken
  `WPM_ASSERT_NEXT(a_out_hold, out_hold, $stable(out_word), "result changed under stall")
  // an error result never reports a match
  `WPM_ASSERT_NOW(a_err_no_match, err_result, !matched_r, "match reported with error")
  // a finish request at the tail always lands in the result register
  `WPM_ASSERT_NEXT(a_finish_lands, adv && tail_finish, out_valid_r, "finish lost at tail")

endmodule
